/* sv/assert_macros.svh */
// Assertion helpers used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/cct_pkg.sv */
package cct_pkg;

  // Default width of the blank run counter
  localparam int SPACE_COUNT_BITS_DEF = 16;
  // Width of the reported blank count
  localparam int SPACE_REC_BITS = 16;

  // Token classes as reported in token_class
  localparam logic [1:0] CLS_DIGIT = 2'd0;
  localparam logic [1:0] CLS_ALPHA = 2'd1;
  localparam logic [1:0] CLS_OTHER = 2'd2;

  // Blank characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  typedef enum logic [1:0] {
    ST_SPACE = 2'd0,
    ST_DIGIT = 2'd1,
    ST_ALPHA = 2'd2,
    ST_OTHER = 2'd3
  } scan_state_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_string;
  } byte_item_t;

  typedef struct packed {
    logic                      closes_token;
    logic                      spaces_valid;
    logic [SPACE_REC_BITS-1:0] space_count;
    logic                      char_valid;
    logic [7:0]                char_out;
    logic                      starts_token;
    logic [1:0]                token_class;
    logic                      string_done;
  } tok_item_t;

  // ASCII class of a non-blank byte
  function automatic logic [1:0] class_of(input logic [7:0] c);
    logic [1:0] cls;
    if (c >= 8'h30 && c <= 8'h39) begin
      cls = CLS_DIGIT;
    end else if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
      cls = CLS_ALPHA;
    end else begin
      cls = CLS_OTHER;
    end
    return cls;
  endfunction

endpackage

/* sv/cct_step.sv */
// Per-byte tokenizer logic: result beat, next scan state and next blank run
module cct_step import cct_pkg::*; #(
  parameter int SPACE_COUNT_BITS = SPACE_COUNT_BITS_DEF
) (
  input  byte_item_t                  item,
  input  scan_state_t                 state,
  input  logic [SPACE_COUNT_BITS-1:0] run,
  output tok_item_t                   res,
  output scan_state_t                 state_next,
  output logic [SPACE_COUNT_BITS-1:0] run_next
);

  localparam logic [SPACE_COUNT_BITS-1:0] RunMax = '1;

  logic [SPACE_REC_BITS-1:0] rec;
  logic [1:0]                cls;
  logic                      cont;

  // Blank run as reported, clipped to the report width
  generate
    if (SPACE_COUNT_BITS > SPACE_REC_BITS) begin : g_clip
      assign rec = (|run[SPACE_COUNT_BITS-1:SPACE_REC_BITS]) ? '1
                                                             : run[SPACE_REC_BITS-1:0];
    end else if (SPACE_COUNT_BITS == SPACE_REC_BITS) begin : g_same
      assign rec = run;
    end else begin : g_ext
      assign rec = {{(SPACE_REC_BITS-SPACE_COUNT_BITS){1'b0}}, run};
    end
  endgenerate

  assign cls  = class_of(item.ch);
  assign cont = (state == ST_DIGIT && cls == CLS_DIGIT) ||
                (state == ST_ALPHA && cls == CLS_ALPHA);

  // Token decision for one byte
  always_comb begin
    res        = '0;
    state_next = state;
    run_next   = run;
    if (item.end_of_string) begin
      // terminator: close, record blanks, back to reset state
      res.closes_token = (state != ST_SPACE);
      res.spaces_valid = 1'b1;
      res.space_count  = rec;
      res.string_done  = 1'b1;
      state_next       = ST_SPACE;
      run_next         = '0;
    end else if (item.ch == CH_SPACE || item.ch == CH_TAB) begin
      res.closes_token = (state != ST_SPACE);
      if (run != RunMax) begin
        run_next = run + 1'b1;
      end
      state_next = ST_SPACE;
    end else begin
      res.char_valid  = 1'b1;
      res.char_out    = item.ch;
      res.token_class = cls;
      if (!cont) begin
        // new token begins here
        res.closes_token = (state != ST_SPACE);
        res.spaces_valid = 1'b1;
        res.space_count  = rec;
        res.starts_token = 1'b1;
        run_next         = '0;
        case (cls)
          CLS_DIGIT: state_next = ST_DIGIT;
          CLS_ALPHA: state_next = ST_ALPHA;
          default:   state_next = ST_OTHER;
        endcase
      end
    end
  end

endmodule

/* sv/char_class_tokenizer_fsm.sv */
// Character-class tokenizer.
// Input channel (byte_valid / byte_stall / byte_item): one beat per text byte,
// then one beat with end_of_string set to close the string.
// Output channel (tok_valid / tok_stall / tok_item): exactly one beat per input
// beat, in order, carrying close/start marks, the blank count and the byte.
// An accepted beat passes through the input register, then the result register.
// Throughput: one beat per cycle while tok_stall is low; the scan state and
// blank run update as a beat moves from the input register to the result register.
// Stall: a stalled result holds in the result register while one more beat
// sits in the input register; byte_stall rises only when both are full.
// Reset (rst, synchronous, active high) empties both registers and returns
// the scanner to the between-tokens state with a zero blank run.
// After a terminator beat the scanner is in reset state for the next string.
module char_class_tokenizer_fsm import cct_pkg::*; #(
  parameter int SPACE_COUNT_BITS = SPACE_COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  byte_item_t byte_item,
  output logic       tok_valid,
  input  logic       tok_stall,
  output tok_item_t  tok_item
);

  `include "assert_macros.svh"

  logic                        s1_vld;
  byte_item_t                  s1_item;
  logic                        out_vld;
  tok_item_t                   out_item;
  scan_state_t                 scan_state;
  scan_state_t                 scan_state_next;
  logic [SPACE_COUNT_BITS-1:0] space_run;
  logic [SPACE_COUNT_BITS-1:0] space_run_next;
  tok_item_t                   res;
  logic                        out_free;
  logic                        move;

  assign out_free   = !out_vld || !tok_stall;
  assign move       = s1_vld && out_free;
  assign byte_stall = s1_vld && !out_free;
  assign tok_valid  = out_vld;
  assign tok_item   = out_item;

  cct_step #(
    .SPACE_COUNT_BITS(SPACE_COUNT_BITS)
  ) u_step (
    .item      (s1_item),
    .state     (scan_state),
    .run       (space_run),
    .res       (res),
    .state_next(scan_state_next),
    .run_next  (space_run_next)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (!byte_stall) begin
      s1_vld <= byte_valid;
    end
    if (!byte_stall) begin
      s1_item <= byte_item;
    end
  end

  // Scan state, updated as a beat moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state <= ST_SPACE;
      space_run  <= '0;
    end else if (move) begin
      scan_state <= scan_state_next;
      space_run  <= space_run_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (out_free) begin
      out_vld <= move;
    end
    if (move) begin
      out_item <= res;
    end
  end

  // Terminator leaves the scanner in reset state
  `ASSERT_NEXT(a_eos_resets, clk, rst, move && s1_item.end_of_string,
               scan_state == ST_SPACE && space_run == '0)
  // Held result and scan state describe the same token
  `ASSERT_IMPL(a_class_state, clk, rst, out_vld && out_item.char_valid,
               (out_item.token_class == CLS_DIGIT) == (scan_state == ST_DIGIT))
  // Input is held off only while both registers are full
  `ASSERT_IMPL(a_stall_full, clk, rst, byte_stall, s1_vld && out_vld && tok_stall)

endmodule

/* verif/tb.sv */
module tb import cct_pkg::*; ();

  localparam int RUN_BITS = SPACE_COUNT_BITS_DEF;
  localparam int PHASE_ITEMS = 385;
  localparam int TAIL_CYCLES = 12;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PRINT_CAP = 60;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_stall;
  byte_item_t byte_item = '0;
  logic       tok_valid;
  logic       tok_stall = 1'b0;
  tok_item_t  tok_item;

  char_class_tokenizer_fsm dut (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_item (byte_item),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok_item  (tok_item)
  );

  always #2 clk = ~clk;

  // text bytes waiting to go out, and the token results they should produce
  byte_item_t text_q[$];
  tok_item_t  want_tok_q[$];

  int bytes_queued = 0;
  int bytes_taken = 0;
  int toks_seen = 0;
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int watch_cycles;
  logic beat_taken = 1'b0;

  // scanner model state
  scan_state_t         scan_st = ST_SPACE;
  logic [RUN_BITS-1:0] blank_run = '0;

  // ASCII class of a byte that is not a blank
  function automatic logic [1:0] byte_kind(logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) return CLS_DIGIT;
    if (c inside {[8'h41:8'h5A], [8'h61:8'h7A]}) return CLS_ALPHA;
    return CLS_OTHER;
  endfunction

  // blank run as reported, clipped to the record width
  function automatic logic [SPACE_REC_BITS-1:0] blank_record();
    longint unsigned run;
    longint unsigned cap;
    run = blank_run;
    cap = (64'd1 << SPACE_REC_BITS) - 1;
    return (run > cap) ? cap[SPACE_REC_BITS-1:0] : run[SPACE_REC_BITS-1:0];
  endfunction

  // advance the scanner by one beat and return its token result
  function automatic tok_item_t scan_byte(byte_item_t b);
    tok_item_t  r;
    logic [1:0] k;
    logic       same_run;
    r = '0;
    if (b.end_of_string) begin
      r.closes_token = (scan_st != ST_SPACE);
      r.spaces_valid = 1'b1;
      r.space_count  = blank_record();
      r.string_done  = 1'b1;
      scan_st   = ST_SPACE;
      blank_run = '0;
    end else if (b.ch == CH_SPACE || b.ch == CH_TAB) begin
      r.closes_token = (scan_st != ST_SPACE);
      if (blank_run != '1) blank_run = blank_run + 1'b1;
      scan_st = ST_SPACE;
    end else begin
      k = byte_kind(b.ch);
      same_run = (scan_st == ST_DIGIT && k == CLS_DIGIT) ||
                 (scan_st == ST_ALPHA && k == CLS_ALPHA);
      r.char_valid  = 1'b1;
      r.char_out    = b.ch;
      r.token_class = k;
      if (!same_run) begin
        r.closes_token = (scan_st != ST_SPACE);
        r.spaces_valid = 1'b1;
        r.space_count  = blank_record();
        r.starts_token = 1'b1;
        blank_run = '0;
        scan_st = (k == CLS_DIGIT) ? ST_DIGIT : (k == CLS_ALPHA) ? ST_ALPHA : ST_OTHER;
      end
    end
    return r;
  endfunction

  task automatic note_mismatch(string what, longint unsigned got, longint unsigned want);
    if (mismatches < PRINT_CAP)
      $display("mismatch: result %0d %s got 0x%0h want 0x%0h", toks_seen, what, got, want);
    mismatches++;
  endtask

  task automatic check_tok(tok_item_t got, tok_item_t want);
    if (got.closes_token !== want.closes_token)
      note_mismatch("closes_token", got.closes_token, want.closes_token);
    if (got.spaces_valid !== want.spaces_valid)
      note_mismatch("spaces_valid", got.spaces_valid, want.spaces_valid);
    if (got.space_count !== want.space_count)
      note_mismatch("space_count", got.space_count, want.space_count);
    if (got.char_valid !== want.char_valid)
      note_mismatch("char_valid", got.char_valid, want.char_valid);
    if (got.char_out !== want.char_out)
      note_mismatch("char_out", got.char_out, want.char_out);
    if (got.starts_token !== want.starts_token)
      note_mismatch("starts_token", got.starts_token, want.starts_token);
    if (got.token_class !== want.token_class)
      note_mismatch("token_class", got.token_class, want.token_class);
    if (got.string_done !== want.string_done)
      note_mismatch("string_done", got.string_done, want.string_done);
  endtask

  // ---- stimulus builders ----
  task automatic push_byte(logic [7:0] c, logic eos);
    byte_item_t b;
    b.ch = c;
    b.end_of_string = eos;
    text_q.insert(text_q.size(), b);
    bytes_queued++;
  endtask

  function automatic logic [7:0] rand_digit();
    return 8'h30 + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_letter();
    logic [7:0] base;
    base = $urandom_range(1) ? 8'h61 : 8'h41;
    return base + 8'($urandom_range(25));
  endfunction

  // any byte of class other that is not a blank
  function automatic logic [7:0] rand_other();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (byte_kind(c) != CLS_OTHER || c == CH_SPACE || c == CH_TAB)
      c = 8'($urandom_range(255));
    return c;
  endfunction

  task automatic push_blanks(int n);
    int i;
    for (i = 0; i < n; i++) push_byte($urandom_range(1) ? CH_SPACE : CH_TAB, 1'b0);
  endtask

  function automatic int rand_gap();
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 40);
    return $urandom_range(41, 600);
  endfunction

  // one well-formed string of random tokens, closed by a terminator
  task automatic push_string();
    int ntok;
    int t;
    int j;
    int len;
    ntok = $urandom_range(0, 8);
    if ($urandom_range(2) == 0) push_blanks(rand_gap());
    for (t = 0; t < ntok; t++) begin
      case ($urandom_range(2))
        0: begin
          len = $urandom_range(1, 6);
          for (j = 0; j < len; j++) push_byte(rand_digit(), 1'b0);
        end
        1: begin
          len = $urandom_range(1, 6);
          for (j = 0; j < len; j++) push_byte(rand_letter(), 1'b0);
        end
        default: push_byte(rand_other(), 1'b0);
      endcase
      if (t != ntok - 1) push_blanks(rand_gap());
    end
    if ($urandom_range(2) == 0) push_blanks(rand_gap());
    push_byte(8'($urandom_range(255)), 1'b1);
  endtask

  // mostly well-formed strings, some bursts of raw bytes
  task automatic push_random(int target);
    int stop_at;
    int n;
    int i;
    stop_at = bytes_queued + target;
    while (bytes_queued < stop_at) begin
      if ($urandom_range(99) < 85) begin
        push_string();
      end else begin
        n = $urandom_range(1, 8);
        for (i = 0; i < n; i++)
          push_byte(8'($urandom_range(255)), $urandom_range(15) == 0);
      end
    end
  endtask

  // class boundaries, blanks, zero and high bytes, terminators after blanks, digits and other bytes
  task automatic push_directed();
    push_byte(CH_SPACE, 1'b0);
    push_byte(CH_TAB, 1'b0);
    push_byte(8'h30, 1'b0);
    push_byte(8'h39, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(8'h5A, 1'b0);
    push_byte(8'h61, 1'b0);
    push_byte(8'h7A, 1'b0);
    push_byte(8'h2F, 1'b0);
    push_byte(8'h3A, 1'b0);
    push_byte(8'h40, 1'b0);
    push_byte(8'h5B, 1'b0);
    push_byte(8'h60, 1'b0);
    push_byte(8'h7B, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h31, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(CH_SPACE, 1'b0);
    push_byte(CH_TAB, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h35, 1'b0);
    push_byte(8'h20, 1'b1);
  endtask

  // wait until every byte has gone in and every result has come out
  task automatic drain();
    while (bytes_taken != bytes_queued || want_tok_q.size() != 0) @(negedge clk);
  endtask

  // ---- sender ----
  always @(negedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!byte_valid || beat_taken) begin
      if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        byte_item  <= text_q.pop_front();
        byte_valid <= 1'b1;
      end else begin
        byte_valid <= 1'b0;
      end
    end
  end

  // ---- receiver stall ----
  always @(negedge clk) begin
    tok_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // ---- input beats: predict ----
  always @(posedge clk) begin
    beat_taken <= !rst && byte_valid && !byte_stall;
    if (!rst && byte_valid && !byte_stall) begin
      want_tok_q.insert(want_tok_q.size(), scan_byte(byte_item));
      bytes_taken++;
    end
  end

  // ---- output beats: check against oldest expectation ----
  always @(posedge clk) begin
    if (!rst && tok_valid && !tok_stall) begin
      if (want_tok_q.size() == 0) begin
        note_mismatch("tok_valid with nothing expected", 1, 0);
      end else begin
        check_tok(tok_item, want_tok_q.pop_front());
      end
      toks_seen++;
    end
  end

  // ---- timeout ----
  initial begin
    for (watch_cycles = 0; watch_cycles < CYCLE_LIMIT; watch_cycles++) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  // ---- run sequence ----
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // phase 1: sender idles lightly, receiver stalls heavily
    send_idle_pct = 23;
    recv_idle_pct = 63;
    push_directed();
    push_random(PHASE_ITEMS);
    drain();

    // phase 2: the other way round
    send_idle_pct = 63;
    recv_idle_pct = 23;
    push_random(PHASE_ITEMS);
    drain();

    // phase 3: full rate
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_random(PHASE_ITEMS);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && want_tok_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
